// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dpu_pkg.sv =====
`timescale 1ns / 1ps
package dpu_pkg;

   localparam int PAGE_BYTES_DEF      = 16;
   localparam int VIRTUAL_PAGES_DEF   = 16;
   localparam int PHYSICAL_FRAMES_DEF = 4;
   localparam int SWAP_SLOTS_DEF      = 16;

   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int CNT_W  = 32;
   localparam logic [DATA_W-1:0] AGE_MSB = 8'h80;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // Sequencer states of the paging engine.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SLOT,
      ST_EVICT_RD,
      ST_EVICT_WR,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_ACCESS,
      ST_DATA,
      ST_DONE
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage

// ===== design/dpu_page_mem.sv =====
`timescale 1ns / 1ps
// Generic synchronous single-port RAM with registered read data.
module dpu_page_mem import dpu_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];

   // Read before write, read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== design/demand_paging_unit.sv =====
`timescale 1ns / 1ps
// Demand paging unit.
// req_ channel: one transaction per byte read, byte write or aging tick
// (opcode, address, write_data). rsp_ channel: one result transaction per
// request with read_data, ok, page_fault, did_writeback and three saturating
// counters. csr_ channel: writes the replacement policy (0 FIFO, 1 aging
// LRU); write it only while no request is in flight.
// Flow: a tick or an unused opcode goes from lookup straight to respond; a hit
// goes through access and data capture. A fault first scans for a free frame,
// then, when no frame is free, scans for a victim by the policy, and then
// decides; a dirty victim without a swap slot adds a search for a free slot.
// Page copies move one byte at a time through the single-port frame and swap
// RAMs, a read state then a write state per byte: the writeback of the victim
// first, then the load of the new page, then the access and the response.
// One request is in flight at a time; the next is accepted in the cycle after
// the response is written, so a new request is never taken before the response
// of the last one is written.
// Reset (synchronous, active high) empties the page table, frees frames 1
// and up, marks frame 0 protected, clears counters and sets policy to LRU.
// A stalled rsp_ready holds the response; the next request can still be taken but waits in ST_DONE until it is.
module demand_paging_unit import dpu_pkg::*; #(
   parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
   parameter int VIRTUAL_PAGES   = VIRTUAL_PAGES_DEF,
   parameter int PHYSICAL_FRAMES = PHYSICAL_FRAMES_DEF,
   parameter int SWAP_SLOTS      = SWAP_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_ok,
   output logic              rsp_page_fault,
   output logic              rsp_did_writeback,
   output logic [CNT_W-1:0]  rsp_access_count,
   output logic [CNT_W-1:0]  rsp_fault_count,
   output logic [CNT_W-1:0]  rsp_writeback_count,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_replacement_policy
);
   localparam int OW  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
   localparam int VW  = (VIRTUAL_PAGES > 1) ? $clog2(VIRTUAL_PAGES) : 1;
   localparam int FW  = (PHYSICAL_FRAMES > 1) ? $clog2(PHYSICAL_FRAMES) : 1;
   localparam int SW  = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
   localparam int FCW = $clog2(PHYSICAL_FRAMES + 1);
   localparam int SCW = $clog2(SWAP_SLOTS + 1);
   localparam int BCW = $clog2(PAGE_BYTES + 1);
   localparam int FMW = FW + OW;
   localparam int SMW = SW + OW;

   // Page table and frame table registers.
   logic [VIRTUAL_PAGES-1:0]   pv_ff, pd_ff, phs_ff;
   logic [FW-1:0]              pf_ff [VIRTUAL_PAGES];
   logic [SW-1:0]              ps_ff [VIRTUAL_PAGES];
   logic [PHYSICAL_FRAMES-1:0] fo_ff, fp_ff, fd_ff, fr_ff;
   logic [VW-1:0]              fown_ff [PHYSICAL_FRAMES];
   logic [DATA_W-1:0]          fage_ff [PHYSICAL_FRAMES];
   logic [SWAP_SLOTS-1:0]      su_ff;
   logic [FW-1:0]              rr_ff;
   logic                       pol_ff;
   logic [CNT_W-1:0]           acc_ff, flt_ff, wbc_ff;

   // Request and walk registers.
   state_type            state_ff, state_in;
   opcode_type           op_ff;
   logic [VW-1:0]        vpn_ff;
   logic [OW-1:0]        off_ff;
   logic [DATA_W-1:0]    wd_ff;
   logic [FW-1:0]        fr_sel_ff;
   logic [FCW-1:0]       fi_ff;
   logic                 found_ff;
   logic [DATA_W:0]      best_ff;
   logic [1:0]           phase_ff;
   logic [SCW-1:0]       si_ff;
   logic [BCW-1:0]       bi_ff;
   logic [SW-1:0]        wslot_ff;
   logic                 wb_ff, fault_ff, okr_ff, load_swap_ff;
   logic [SW-1:0]        lslot_ff;
   logic [DATA_W-1:0]    cpy_ff;

   // Response register.
   logic              rv_ff;
   logic [DATA_W-1:0] rrd_ff;
   logic              rok_ff, rpf_ff, rwb_ff;
   logic [CNT_W-1:0]  racc_ff, rflt_ff, rwbc_ff;

   // Memory ports.
   logic              fm_we, sm_we;
   logic [FMW-1:0]    fm_addr;
   logic [SMW-1:0]    sm_addr;
   logic [DATA_W-1:0] fm_wd, sm_wd, fm_rd, sm_rd;

   dpu_page_mem #(.DEPTH(PHYSICAL_FRAMES * PAGE_BYTES), .AW(FMW)) u_frame_mem (
      .clock(clock), .wr_en(fm_we), .addr(fm_addr), .wr_data(fm_wd), .rd_data(fm_rd));
   dpu_page_mem #(.DEPTH(SWAP_SLOTS * PAGE_BYTES), .AW(SMW)) u_swap_mem (
      .clock(clock), .wr_en(sm_we), .addr(sm_addr), .wr_data(sm_wd), .rd_data(sm_rd));

   logic accept, rsp_free, fault_walk_end;
   logic [FW-1:0] fi_idx, owner_frame;
   logic [VW-1:0] owner;
   logic [FW:0]   rr_sum;
   logic [FW-1:0] rr_cand;
   assign rsp_free  = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign fi_idx    = fi_ff[FW-1:0];
   assign owner     = fown_ff[fr_sel_ff];
   assign owner_frame = fr_sel_ff;
   assign fault_walk_end = (fi_ff == FCW'(PHYSICAL_FRAMES));

   // FIFO candidate: the pointer plus the walk index, wrapped at the frame count.
   assign rr_sum  = {1'b0, rr_ff} + {1'b0, fi_idx};
   assign rr_cand = (rr_sum >= (FW+1)'(PHYSICAL_FRAMES)) ?
                    FW'(rr_sum - (FW+1)'(PHYSICAL_FRAMES)) : rr_sum[FW-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP: begin
            if (op_ff == OP_TICK || op_ff == OP_NONE) state_in = ST_DONE;
            else if (pv_ff[vpn_ff]) state_in = ST_ACCESS;
            else if (fault_walk_end && phase_ff == 2'd2) begin
               if (!found_ff) state_in = ST_DONE;
               else if (!fo_ff[fr_sel_ff]) state_in = ST_LOAD_RD;
               else if ((pd_ff[owner] || fd_ff[fr_sel_ff]) && !phs_ff[owner])
                  state_in = ST_SLOT;
               else if (pd_ff[owner] || fd_ff[fr_sel_ff]) state_in = ST_EVICT_RD;
               else state_in = ST_LOAD_RD;
            end
         end
         ST_SLOT: begin
            if (si_ff == SCW'(SWAP_SLOTS)) state_in = ST_LOAD_RD;
            else if (!su_ff[si_ff[SW-1:0]]) state_in = ST_EVICT_RD;
         end
         ST_EVICT_RD: state_in = ST_EVICT_WR;
         ST_EVICT_WR: state_in = (bi_ff == BCW'(PAGE_BYTES - 1)) ? ST_LOAD_RD : ST_EVICT_RD;
         ST_LOAD_RD:  state_in = ST_LOAD_WR;
         ST_LOAD_WR:  state_in = (bi_ff == BCW'(PAGE_BYTES - 1)) ? ST_ACCESS : ST_LOAD_RD;
         ST_ACCESS:   state_in = ST_DATA;
         ST_DATA:     state_in = ST_DONE;
         ST_DONE:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Memory port drive.
   always_comb begin
      fm_we = 1'b0; sm_we = 1'b0;
      fm_addr = {fr_sel_ff, bi_ff[OW-1:0]};
      sm_addr = {wslot_ff, bi_ff[OW-1:0]};
      fm_wd = cpy_ff; sm_wd = fm_rd;
      unique case (state_ff)
         ST_EVICT_WR: sm_we = 1'b1;
         ST_LOAD_RD:  sm_addr = {lslot_ff, bi_ff[OW-1:0]};
         ST_LOAD_WR: begin
            fm_we = 1'b1;
            fm_wd = load_swap_ff ? sm_rd : '0;
         end
         ST_ACCESS: begin
            fm_addr = {fr_sel_ff, off_ff};
            fm_we = (op_ff == OP_WRITE);
            fm_wd = wd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff <= '0; pd_ff <= '0; phs_ff <= '0; su_ff <= '0;
         fo_ff <= PHYSICAL_FRAMES'(1); fp_ff <= PHYSICAL_FRAMES'(1);
         fd_ff <= '0; fr_ff <= '0;
         for (int i = 0; i < VIRTUAL_PAGES; i++) begin
            pf_ff[i] <= '0; ps_ff[i] <= '0;
         end
         for (int i = 0; i < PHYSICAL_FRAMES; i++) begin
            fown_ff[i] <= '0; fage_ff[i] <= '0;
         end
         rr_ff <= FW'(1 % PHYSICAL_FRAMES);
         pol_ff <= 1'b1;
         acc_ff <= '0; flt_ff <= '0; wbc_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) pol_ff <= csr_replacement_policy;
         if (rv_ff && rsp_ready && state_ff != ST_DONE) rv_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               op_ff  <= opcode_type'(req_opcode);
               vpn_ff <= VW'(req_address >> OW);
               off_ff <= req_address[OW-1:0];
               wd_ff  <= req_write_data;
               fi_ff <= '0; found_ff <= 1'b0; best_ff <= 9'h100; phase_ff <= '0;
               wb_ff <= 1'b0; fault_ff <= 1'b0; okr_ff <= 1'b0;
               si_ff <= '0; bi_ff <= '0;
               if (accept && (req_opcode == OP_READ || req_opcode == OP_WRITE))
                  acc_ff <= sat_inc(acc_ff);
            end
            ST_LOOKUP: begin
               if (op_ff == OP_TICK) begin
                  // Age every occupied, unprotected frame.
                  for (int i = 0; i < PHYSICAL_FRAMES; i++)
                     if (!fp_ff[i] && fo_ff[i]) begin
                        fage_ff[i] <= (fage_ff[i] >> 1) | (fr_ff[i] ? AGE_MSB : '0);
                        fr_ff[i] <= 1'b0;
                     end
                  okr_ff <= 1'b1;
               end else if (op_ff == OP_NONE) begin
                  okr_ff <= 1'b0;
               end else if (pv_ff[vpn_ff]) begin
                  fr_sel_ff <= pf_ff[vpn_ff];
                  okr_ff <= 1'b1;
               end else if (!fault_walk_end) begin
                  // One frame examined per cycle.
                  fi_ff <= fi_ff + FCW'(1);
                  unique case (phase_ff)
                     2'd0: if (!found_ff && !fp_ff[fi_idx] && !fo_ff[fi_idx]) begin
                        found_ff <= 1'b1; fr_sel_ff <= fi_idx;
                     end
                     2'd1: if (!pol_ff) begin
                        if (!found_ff && !fp_ff[rr_cand]) begin
                           found_ff <= 1'b1;
                           fr_sel_ff <= rr_cand;
                        end
                     end else if (!fp_ff[fi_idx] && {1'b0, fage_ff[fi_idx]} < best_ff) begin
                        best_ff <= {1'b0, fage_ff[fi_idx]};
                        found_ff <= 1'b1; fr_sel_ff <= fi_idx;
                     end
                     default: ;
                  endcase
               end else if (phase_ff == 2'd0) begin
                  fault_ff <= 1'b1;
                  flt_ff <= sat_inc(flt_ff);
                  if (!found_ff) fi_ff <= '0;
                  phase_ff <= found_ff ? 2'd2 : 2'd1;
               end else if (phase_ff == 2'd1) begin
                  phase_ff <= 2'd2;
                  if (!pol_ff && found_ff)
                     rr_ff <= (fr_sel_ff == FW'(PHYSICAL_FRAMES - 1)) ?
                              '0 : fr_sel_ff + FW'(1);
               end else if (found_ff) begin
                  okr_ff <= 1'b1;
                  wslot_ff <= ps_ff[owner];
                  lslot_ff <= ps_ff[vpn_ff];
                  load_swap_ff <= phs_ff[vpn_ff] && su_ff[ps_ff[vpn_ff]];
                  bi_ff <= '0;
                  if (!fo_ff[fr_sel_ff]) ;
                  else if (!(pd_ff[owner] || fd_ff[fr_sel_ff]) || phs_ff[owner]) begin
                     if (pd_ff[owner] || fd_ff[fr_sel_ff]) begin
                        wb_ff <= 1'b1; wbc_ff <= sat_inc(wbc_ff);
                     end
                     pv_ff[owner] <= 1'b0; pd_ff[owner] <= 1'b0; pf_ff[owner] <= '0;
                  end
               end
            end
            ST_SLOT: begin
               // Find the first free swap slot for the victim's page.
               si_ff <= si_ff + SCW'(1);
               if (si_ff == SCW'(SWAP_SLOTS)) begin
                  pv_ff[owner] <= 1'b0; pd_ff[owner] <= 1'b0; pf_ff[owner] <= '0;
               end else if (!su_ff[si_ff[SW-1:0]]) begin
                  su_ff[si_ff[SW-1:0]] <= 1'b1;
                  phs_ff[owner] <= 1'b1;
                  ps_ff[owner] <= si_ff[SW-1:0];
                  wslot_ff <= si_ff[SW-1:0];
                  wb_ff <= 1'b1; wbc_ff <= sat_inc(wbc_ff);
                  pv_ff[owner] <= 1'b0; pd_ff[owner] <= 1'b0; pf_ff[owner] <= '0;
               end
            end
            ST_EVICT_WR: bi_ff <= (bi_ff == BCW'(PAGE_BYTES - 1)) ? '0 : bi_ff + BCW'(1);
            ST_LOAD_WR: begin
               bi_ff <= bi_ff + BCW'(1);
               if (bi_ff == BCW'(PAGE_BYTES - 1)) begin
                  // Install the new mapping.
                  pv_ff[vpn_ff] <= 1'b1; pd_ff[vpn_ff] <= 1'b0; pf_ff[vpn_ff] <= owner_frame;
                  fo_ff[fr_sel_ff] <= 1'b1; fp_ff[fr_sel_ff] <= 1'b0;
                  fd_ff[fr_sel_ff] <= 1'b0; fr_ff[fr_sel_ff] <= 1'b1;
                  fown_ff[fr_sel_ff] <= vpn_ff; fage_ff[fr_sel_ff] <= AGE_MSB;
               end
            end
            ST_ACCESS: begin
               if (op_ff == OP_WRITE) begin
                  pd_ff[vpn_ff] <= 1'b1; fd_ff[fr_sel_ff] <= 1'b1;
               end
               fr_ff[fr_sel_ff] <= 1'b1;
            end
            ST_DONE: if (rsp_free) begin
               rv_ff <= 1'b1;
               rrd_ff <= (okr_ff && op_ff == OP_READ) ? cpy_ff : '0;
               rok_ff <= okr_ff; rpf_ff <= fault_ff; rwb_ff <= wb_ff;
               racc_ff <= acc_ff; rflt_ff <= flt_ff; rwbc_ff <= wbc_ff;
            end
            default: ;
         endcase
      end
   end

   // Read data capture: the byte fetched by the final access.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DATA) cpy_ff <= fm_rd;
      else if (state_ff == ST_IDLE) cpy_ff <= '0;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_read_data       = rrd_ff;
   assign rsp_ok              = rok_ff;
   assign rsp_page_fault      = rpf_ff;
   assign rsp_did_writeback   = rwb_ff;
   assign rsp_access_count    = racc_ff;
   assign rsp_fault_count     = rflt_ff;
   assign rsp_writeback_count = rwbc_ff;
endmodule

// ===== design/dpu_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks of the paging unit.
module dpu_checker import dpu_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_ok,
   input logic             rsp_page_fault,
   input logic             rsp_did_writeback,
   input logic [CNT_W-1:0] rsp_access_count,
   input logic [CNT_W-1:0] rsp_fault_count
);
   `CHK_IMPLY(a_wb_needs_fault, clock, reset, rsp_valid && rsp_did_writeback,
              rsp_page_fault, "writeback without fault")
   `CHK_IMPLY(a_fault_le_access, clock, reset, rsp_valid,
              rsp_fault_count <= rsp_access_count, "faults exceed accesses")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
             rsp_valid && $stable(rsp_access_count), "response dropped")
   `CHK_IMPLY(a_wb_ok, clock, reset, rsp_valid && rsp_did_writeback,
              rsp_ok, "writeback on failed access")
   // Only one request is in flight, so the request side closes once a request is accepted.
   `CHK_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready,
             !req_ready, "second request taken while busy")
endmodule

bind demand_paging_unit dpu_checker u_dpu_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ok(rsp_ok),
   .rsp_page_fault(rsp_page_fault), .rsp_did_writeback(rsp_did_writeback),
   .rsp_access_count(rsp_access_count), .rsp_fault_count(rsp_fault_count));
